// File: sv/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the averager modules.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fca_pkg.sv
// ------------------------------------------------------------------------
// fca_pkg
// Types and constants shared by the flagged channel averager modules.
// ------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

	localparam int SUM_W      = 36;
	localparam int CNT_W      = 13;
	localparam int FIRST_W    = 12;
	localparam int FRAC_W     = 16;
	localparam int WEIGHT_W   = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CNT_W-1:0]    POS_MAX    = 13'd8191;
	localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = 17'd65536;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHANNEL = 2'd2;

	// group queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// one quotient bit per divider step
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int OUT_DATA_W = ((2 * SUM_W + WEIGHT_W + 7) / 8) * 8;

	// closed group handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0] good_re;
		logic signed [SUM_W-1:0] good_im;
		logic signed [SUM_W-1:0] all_re;
		logic signed [SUM_W-1:0] all_im;
		logic [CNT_W-1:0]        good_cnt;
		logic [CNT_W-1:0]        grp_len;
		logic                    last;
	} grp_t;

endpackage

`default_nettype wire

// File: sv/fca_front.sv
// ------------------------------------------------------------------------
// fca_front
// Holds the registers, tracks row position, accumulates groups and
// pushes each closed group into the queue.
// ------------------------------------------------------------------------
`default_nettype none

module fca_front import fca_pkg::*; #(
	parameter int MAX_CHANNELS = 4096,
	parameter int SAMPLE_BITS  = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] sample_real,
	input  wire logic [SAMPLE_BITS-1:0] sample_imag,
	input  wire logic                   flagged,
	input  wire logic                   end_of_row,
	input  wire logic                   q_full,
	output logic                        q_push,
	output grp_t                        q_data
);

	localparam int CC_MIN = $clog2(MAX_CHANNELS + 1);
	localparam int CC_W   = (CC_MIN > CNT_W) ? CC_MIN : CNT_W;
	localparam int END_W  = CC_W + 1;

	logic [CNT_W-1:0]   gsize_q;
	logic [CC_W-1:0]    count_q;
	logic [FIRST_W-1:0] first_q;

	logic [CNT_W-1:0]        row_pos_q;
	logic [CNT_W-1:0]        grp_len_q;
	logic [CNT_W-1:0]        good_cnt_q;
	logic signed [SUM_W-1:0] good_re_q, good_im_q, all_re_q, all_im_q;

	logic                    accept;
	logic [END_W-1:0]        end_pos;
	logic [END_W-1:0]        pos_ext;
	logic [CNT_W-1:0]        gs;
	logic                    taken, good, at_end, close, last;
	logic signed [SUM_W-1:0] re_ext, im_ext;
	grp_t                    upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= CNT_W'(1);
			count_q <= CC_W'(MAX_CHANNELS);
			first_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GROUP_SIZE:    gsize_q <= cfg_wdata;
				CFG_CHANNEL_COUNT: count_q <= CC_W'(cfg_wdata);
				CFG_FIRST_CHANNEL: first_q <= cfg_wdata[FIRST_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = !q_full;

	always_comb begin
		end_pos = END_W'(first_q) + END_W'(count_q);
		pos_ext = END_W'(row_pos_q);
		gs      = (gsize_q == '0) ? CNT_W'(1) : gsize_q;
		taken   = (row_pos_q >= CNT_W'(first_q)) && (pos_ext < end_pos) &&
			(row_pos_q != POS_MAX);
		good    = taken && !flagged;
		at_end  = taken && (pos_ext == end_pos - END_W'(1));
		re_ext  = SUM_W'($signed(sample_real));
		im_ext  = SUM_W'($signed(sample_imag));

		upd.all_re   = taken ? all_re_q + re_ext : all_re_q;
		upd.all_im   = taken ? all_im_q + im_ext : all_im_q;
		upd.good_re  = good ? good_re_q + re_ext : good_re_q;
		upd.good_im  = good ? good_im_q + im_ext : good_im_q;
		upd.good_cnt = good_cnt_q + CNT_W'(good);
		upd.grp_len  = grp_len_q + CNT_W'(taken);

		// close on a full group, at the last taken channel, or at row end
		last      = at_end || (end_of_row && upd.grp_len != '0);
		close     = last || (taken && upd.grp_len >= gs);
		upd.last  = last;
	end

	assign q_push = accept && close;
	assign q_data = upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q  <= '0;
			grp_len_q  <= '0;
			good_cnt_q <= '0;
			good_re_q  <= '0;
			good_im_q  <= '0;
			all_re_q   <= '0;
			all_im_q   <= '0;
		end else if (accept) begin
			if (end_of_row) begin
				row_pos_q <= '0;
			end else if (row_pos_q != POS_MAX) begin
				row_pos_q <= row_pos_q + CNT_W'(1);
			end
			if (close) begin
				grp_len_q  <= '0;
				good_cnt_q <= '0;
				good_re_q  <= '0;
				good_im_q  <= '0;
				all_re_q   <= '0;
				all_im_q   <= '0;
			end else begin
				grp_len_q  <= upd.grp_len;
				good_cnt_q <= upd.good_cnt;
				good_re_q  <= upd.good_re;
				good_im_q  <= upd.good_im;
				all_re_q   <= upd.all_re;
				all_im_q   <= upd.all_im;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/fca_queue.sv
// ------------------------------------------------------------------------
// fca_queue
// Short queue of closed groups between the front and the divider.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fca_queue import fca_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  grp_t      push_data,
	output logic      full,
	input  wire logic pop,
	output grp_t      pop_data,
	output logic      empty
);

	grp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && full), "push into full queue")
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(pop && empty), "pop from empty queue")
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

// File: sv/fca_back.sv
// ------------------------------------------------------------------------
// fca_back
// Divides each closed group one quotient bit per cycle and holds the
// result in an output register until it is taken.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fca_back import fca_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  grp_t                     q_data,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [SUM_W-1:0]  avg_real,
	output logic signed [SUM_W-1:0]  avg_imag,
	output logic [WEIGHT_W-1:0]      weight,
	output logic                     all_flagged,
	output logic                     last_of_row
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} bst_t;

	// restoring step: returns {quotient bit, new remainder}
	function automatic logic [CNT_W:0] div_step(
		input logic [CNT_W-1:0] rem,
		input logic             msb,
		input logic [CNT_W-1:0] dvs
	);
		logic [CNT_W:0] trial;
		trial = {rem, msb};
		if (trial >= {1'b0, dvs}) begin
			div_step = {1'b1, CNT_W'(trial - {1'b0, dvs})};
		end else begin
			div_step = {1'b0, trial[CNT_W-1:0]};
		end
	endfunction

	bst_t              state_q;
	grp_t              grp_q;
	logic [SUM_W-1:0]  dvd_re_q, dvd_im_q, dvd_wt_q;
	logic [CNT_W-1:0]  rem_re_q, rem_im_q, rem_wt_q;
	logic              neg_re_q, neg_im_q;
	logic [STEP_W-1:0] step_q;

	logic                    out_valid_q;
	logic signed [SUM_W-1:0] avg_re_q, avg_im_q;
	logic [WEIGHT_W-1:0]     weight_q;
	logic                    all_flag_q, last_q;

	logic [CNT_W:0]   st_re, st_im, st_wt;
	logic             load;
	logic [SUM_W-1:0] q_re, q_im;

	assign st_re = div_step(rem_re_q, dvd_re_q[SUM_W-1], grp_q.good_cnt);
	assign st_im = div_step(rem_im_q, dvd_im_q[SUM_W-1], grp_q.good_cnt);
	assign st_wt = div_step(rem_wt_q, dvd_wt_q[SUM_W-1], grp_q.grp_len);

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load  = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	assign q_re  = neg_re_q ? (~dvd_re_q + SUM_W'(1)) : dvd_re_q;
	assign q_im  = neg_im_q ? (~dvd_im_q + SUM_W'(1)) : dvd_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath: magnitudes in, quotient shifts in from the bottom
	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q    <= q_data;
			neg_re_q <= q_data.good_re[SUM_W-1];
			neg_im_q <= q_data.good_im[SUM_W-1];
			dvd_re_q <= q_data.good_re[SUM_W-1] ? (~q_data.good_re + SUM_W'(1)) :
				q_data.good_re;
			dvd_im_q <= q_data.good_im[SUM_W-1] ? (~q_data.good_im + SUM_W'(1)) :
				q_data.good_im;
			dvd_wt_q <= SUM_W'({q_data.good_cnt, FRAC_W'(0)});
			rem_re_q <= '0;
			rem_im_q <= '0;
			rem_wt_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_re_q <= {dvd_re_q[SUM_W-2:0], st_re[CNT_W]};
			dvd_im_q <= {dvd_im_q[SUM_W-2:0], st_im[CNT_W]};
			dvd_wt_q <= {dvd_wt_q[SUM_W-2:0], st_wt[CNT_W]};
			rem_re_q <= st_re[CNT_W-1:0];
			rem_im_q <= st_im[CNT_W-1:0];
			rem_wt_q <= st_wt[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= grp_q.last;
			if (grp_q.good_cnt == '0) begin
				avg_re_q   <= grp_q.all_re;
				avg_im_q   <= grp_q.all_im;
				weight_q   <= ONE_WEIGHT;
				all_flag_q <= 1'b1;
			end else begin
				avg_re_q   <= q_re;
				avg_im_q   <= q_im;
				weight_q   <= dvd_wt_q[WEIGHT_W-1:0];
				all_flag_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign avg_real    = avg_re_q;
	assign avg_imag    = avg_im_q;
	assign weight      = weight_q;
	assign all_flagged = all_flag_q;
	assign last_of_row = last_q;

	`ASSERT_IMPLY(a_pop_idle, clk, arst_n, q_pop, state_q == ST_IDLE, "pop outside idle")
	`ASSERT_IMPLY(a_step_range, clk, arst_n, state_q == ST_DIV,
		step_q < STEP_W'(DIV_STEPS), "divider step out of range")
	`ASSERT_NEXT(a_load_valid, clk, arst_n, load, out_valid_q, "loaded result not presented")
	`ASSERT_IMPLY(a_weight_range, clk, arst_n, out_valid_q && !all_flag_q,
		weight_q <= ONE_WEIGHT, "weight above one")

endmodule

`default_nettype wire

// File: sv/flagged_channel_averager.sv
// Path: the item that closes a group is pushed into the group queue, popped
//   into the divider once it is idle, taken through its 36 divider steps and
//   then loaded into the output register.
// Throughput: one item per cycle while the group queue has room; the
//   bit-serial divider takes one group at a time, the two-entry group
//   queue absorbs bursts, and the input stalls when it is full.
// ------------------------------------------------------------------------
// flagged_channel_averager
// Averages unflagged complex channel samples of each row in groups, with
// a weight of good count over group length and an all-flagged fallback.
// Reset: arst_n clears row position, sums, queue and output valid at once.
// ------------------------------------------------------------------------
`default_nettype none

module flagged_channel_averager import fca_pkg::*; #(
	parameter int MAX_CHANNELS = 4096,
	parameter int SAMPLE_BITS  = 24,
	localparam int IN_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// input items
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // sample_real, sample_imag, zero pad
	input  wire logic                  s_tuser,  // flagged
	input  wire logic                  s_tlast,  // end_of_row
	// result items
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // avg_real, avg_imag, weight, zero pad
	output logic                       m_tuser,  // all_flagged
	output logic                       m_tlast   // last_of_row
);

	grp_t push_data, pop_data;
	logic q_push, q_pop, q_full, q_empty;

	logic signed [SUM_W-1:0] avg_real, avg_imag;
	logic [WEIGHT_W-1:0]     weight;

	// Front: classify each item against the channel window, accumulate the
	// open group and hand it to the queue when it closes.
	fca_front #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.sample_real (s_tdata[SAMPLE_BITS-1:0]),
		.sample_imag (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.flagged     (s_tuser),
		.end_of_row  (s_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (push_data)
	);

	// Queue: decouple the per-item accumulation from the slow divider.
	fca_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// Back: divide good sums by good count and good count by group length, or pass
	// the all sums when all are flagged, then hold the result until the sink takes it.
	fca_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.avg_real    (avg_real),
		.avg_imag    (avg_imag),
		.weight      (weight),
		.all_flagged (m_tuser),
		.last_of_row (m_tlast)
	);

	// pack the result fields, lowest first, pad to whole bytes
	assign m_tdata = OUT_DATA_W'({weight, avg_imag, avg_real});

endmodule

`default_nettype wire
